// ----- rtl/spadd_pkg.sv -----
// Package: shared widths, opcodes and controller/datapath command and status types.
`timescale 1ns / 1ps
`default_nettype none
package spadd_pkg;

	localparam int COEF_W      = 16;
	localparam int EXP_W       = 10;
	localparam int SUM_W       = 17;
	localparam int TERM_W      = COEF_W + EXP_W;
	localparam int MAX_RESULTS = 32;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
	localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
	localparam logic [1:0] OP_RUN           = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic take;        // input transaction accepted this cycle
		logic start_run;   // rewind merge pointers
		logic load_empty;  // emit the empty result of a run on two empty lists
		logic emit;        // emit one merged term
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic run_op;      // incoming opcode is a run
		logic empty_lists; // both stores hold no terms
		logic final_step;  // the term being merged is the last of the run
		logic out_free;    // output register can take a result this cycle
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/spadd_if.sv -----
// Interfaces: term input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface spadd_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            opcode;
	logic signed [spadd_pkg::COEF_W-1:0]   coefficient;
	logic [spadd_pkg::EXP_W-1:0]           exponent;

	modport source (output valid, output opcode, output coefficient, output exponent,
		input ready);
	modport sink (input valid, input opcode, input coefficient, input exponent,
		output ready);
endinterface

interface spadd_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [spadd_pkg::SUM_W-1:0]    sum_coefficient;
	logic [spadd_pkg::EXP_W-1:0]           sum_exponent;
	logic                                  term_valid;
	logic                                  last_term;
	logic                                  overflow;

	modport source (output valid, output sum_coefficient, output sum_exponent,
		output term_valid, output last_term, output overflow, input ready);
	modport sink (input valid, input sum_coefficient, input sum_exponent,
		input term_valid, input last_term, input overflow, output ready);
endinterface
`default_nettype wire

// ----- rtl/sparse_polynomial_add_merge_core.sv -----
// Sparse polynomial adder: two term stores merged in descending exponent order.
//
// Input channel term_in carries an opcode, a coefficient and an exponent.
// Opcodes 0 and 1 append a term to the first or second store; loads may
// arrive back to back. An append to a full store drops the term and sets
// the overflow flag. Opcode 3 is ignored.
// Opcode 2 runs the merge: results leave on result_out, one per merged term,
// the last marked by last_term. Each result takes a store read (fetch
// state), then a compare/add into the output register (emit state).
// A run on two empty stores gives one empty result on the next cycle.
// No new transaction is taken while a run is in progress or a result
// waits unaccepted in the output register. The run clears both store
// counts and the overflow flag.
// When the receiver stalls, the result holds in the output register and
// the merge waits. Reset clears counts, the flag and the output valid;
// store contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module sparse_polynomial_add_merge_core #(
	parameter int MAX_TERMS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	spadd_in_if.sink  term_in,
	spadd_out_if.source result_out
);

	spadd_pkg::cmd_t cmd;
	spadd_pkg::sts_t sts;

	spadd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (term_in.valid),
		.in_ready (term_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	spadd_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.opcode          (term_in.opcode),
		.coefficient     (term_in.coefficient),
		.exponent        (term_in.exponent),
		.res_valid       (result_out.valid),
		.res_ready       (result_out.ready),
		.sum_coefficient (result_out.sum_coefficient),
		.sum_exponent    (result_out.sum_exponent),
		.term_valid      (result_out.term_valid),
		.last_term       (result_out.last_term),
		.overflow        (result_out.overflow)
	);

endmodule
`default_nettype wire

// ----- rtl/spadd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module spadd_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/spadd_ctrl.sv -----
// Controller: sequences loads, run start, fetch and emit of merged terms.
`timescale 1ns / 1ps
`default_nettype none
module spadd_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire spadd_pkg::sts_t sts,
	output spadd_pkg::cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign in_ready = (state_q == ST_IDLE) && sts.out_free;

	// Decode commands and next state
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.take = in_valid && in_ready;
				if (cmd.take && sts.run_op) begin
					if (sts.empty_lists) begin
						cmd.load_empty = 1'b1;
					end else begin
						cmd.start_run = 1'b1;
						state_nxt     = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = sts.final_step ? ST_IDLE : ST_FETCH;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/spadd_dp.sv -----
// Datapath: term stores, counts, merge pointers, compare/add and output register.
`timescale 1ns / 1ps
`default_nettype none
module spadd_dp #(
	parameter int MAX_TERMS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire spadd_pkg::cmd_t                     cmd,
	output spadd_pkg::sts_t                          sts,
	input  wire logic [1:0]                          opcode,
	input  wire logic signed [spadd_pkg::COEF_W-1:0] coefficient,
	input  wire logic [spadd_pkg::EXP_W-1:0]         exponent,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output logic signed [spadd_pkg::SUM_W-1:0]       sum_coefficient,
	output logic [spadd_pkg::EXP_W-1:0]              sum_exponent,
	output logic                                     term_valid,
	output logic                                     last_term,
	output logic                                     overflow
);

	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int TW = spadd_pkg::TERM_W;
	localparam int EW = spadd_pkg::EXP_W;
	localparam int KW = spadd_pkg::RES_CNT_W;

	logic [CW-1:0] cnt1_q, cnt2_q;
	logic [CW-1:0] ptr1_q, ptr2_q;
	logic [KW-1:0] res_cnt_q;
	logic          ovf_q;
	logic          ovalid_q;

	logic [TW-1:0] rd1, rd2;
	logic          we1, we2;
	logic          full1, full2;

	logic [EW-1:0]                       a_exp, b_exp;
	logic signed [spadd_pkg::COEF_W-1:0] a_coef, b_coef;
	logic                                have_a, have_b;
	logic [CW-1:0]                       ptr1_nxt, ptr2_nxt;
	logic [KW-1:0]                       res_cnt_nxt;
	logic signed [spadd_pkg::SUM_W-1:0]  m_coef;
	logic [EW-1:0]                       m_exp;

	// Append decode
	assign full1 = (cnt1_q == CW'(MAX_TERMS));
	assign full2 = (cnt2_q == CW'(MAX_TERMS));
	assign we1   = cmd.take && (opcode == spadd_pkg::OP_APPEND_FIRST) && !full1;
	assign we2   = cmd.take && (opcode == spadd_pkg::OP_APPEND_SECOND) && !full2;

	spadd_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_first_store (
		.clk   (clk),
		.we    (we1),
		.waddr (cnt1_q[AW-1:0]),
		.wdata ({coefficient, exponent}),
		.raddr (ptr1_q[AW-1:0]),
		.rdata (rd1)
	);

	spadd_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_second_store (
		.clk   (clk),
		.we    (we2),
		.waddr (cnt2_q[AW-1:0]),
		.wdata ({coefficient, exponent}),
		.raddr (ptr2_q[AW-1:0]),
		.rdata (rd2)
	);

	// Merge step: pick the higher exponent, add on a tie
	always_comb begin
		a_exp    = rd1[EW-1:0];
		a_coef   = rd1[TW-1:EW];
		b_exp    = rd2[EW-1:0];
		b_coef   = rd2[TW-1:EW];
		have_a   = ptr1_q < cnt1_q;
		have_b   = ptr2_q < cnt2_q;
		ptr1_nxt = ptr1_q;
		ptr2_nxt = ptr2_q;
		m_coef   = {b_coef[spadd_pkg::COEF_W-1], b_coef};
		m_exp    = b_exp;
		if (have_a && have_b && (a_exp == b_exp)) begin
			m_coef   = {a_coef[spadd_pkg::COEF_W-1], a_coef}
				+ {b_coef[spadd_pkg::COEF_W-1], b_coef};
			m_exp    = a_exp;
			ptr1_nxt = ptr1_q + CW'(1);
			ptr2_nxt = ptr2_q + CW'(1);
		end else if (have_a && (!have_b || (a_exp > b_exp))) begin
			m_coef   = {a_coef[spadd_pkg::COEF_W-1], a_coef};
			m_exp    = a_exp;
			ptr1_nxt = ptr1_q + CW'(1);
		end else begin
			ptr2_nxt = ptr2_q + CW'(1);
		end
		res_cnt_nxt = res_cnt_q + KW'(1);
	end

	// Status to controller
	always_comb begin
		sts.run_op      = (opcode == spadd_pkg::OP_RUN);
		sts.empty_lists = (cnt1_q == '0) && (cnt2_q == '0);
		sts.final_step  = !((ptr1_nxt < cnt1_q) || (ptr2_nxt < cnt2_q))
			|| (res_cnt_nxt == KW'(spadd_pkg::MAX_RESULTS));
		sts.out_free    = !ovalid_q || res_ready;
	end

	// Counts, pointers, overflow flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt1_q    <= '0;
			cnt2_q    <= '0;
			ptr1_q    <= '0;
			ptr2_q    <= '0;
			res_cnt_q <= '0;
			ovf_q     <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			if (we1) begin
				cnt1_q <= cnt1_q + CW'(1);
			end
			if (we2) begin
				cnt2_q <= cnt2_q + CW'(1);
			end
			if (cmd.take && (((opcode == spadd_pkg::OP_APPEND_FIRST) && full1)
				|| ((opcode == spadd_pkg::OP_APPEND_SECOND) && full2))) begin
				ovf_q <= 1'b1;
			end
			if (cmd.start_run) begin
				ptr1_q    <= '0;
				ptr2_q    <= '0;
				res_cnt_q <= '0;
			end
			if (cmd.emit) begin
				ptr1_q    <= ptr1_nxt;
				ptr2_q    <= ptr2_nxt;
				res_cnt_q <= res_cnt_nxt;
				if (sts.final_step) begin
					cnt1_q <= '0;
					cnt2_q <= '0;
					ovf_q  <= 1'b0;
				end
			end
			if (cmd.load_empty) begin
				ovf_q <= 1'b0;
			end
			if (cmd.emit || cmd.load_empty) begin
				ovalid_q <= 1'b1;
			end else if (res_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sum_coefficient <= m_coef;
			sum_exponent    <= m_exp;
			term_valid      <= 1'b1;
			last_term       <= sts.final_step;
			overflow        <= ovf_q;
		end else if (cmd.load_empty) begin
			sum_coefficient <= '0;
			sum_exponent    <= '0;
			term_valid      <= 1'b0;
			last_term       <= 1'b1;
			overflow        <= ovf_q;
		end
	end

	assign res_valid = ovalid_q;

endmodule
`default_nettype wire

// ----- test/tb_sparse_polynomial_add_merge_core.sv -----
// Testbench for the sparse polynomial adder: random load/run traffic checked against a merge predictor.
`timescale 1ns / 1ps
module tb_sparse_polynomial_add_merge_core;

	localparam int          STORE_DEPTH  = 16;
	localparam int          ITEM_TARGET  = 400;
	localparam int          LIMIT_CYCLES = 400000;
	localparam int          LONG_HOLD    = 300;
	localparam logic [1:0]  OP_IGNORED   = 2'd3;

	typedef struct {
		logic signed [spadd_pkg::COEF_W-1:0] coef;
		logic [spadd_pkg::EXP_W-1:0]         expo;
	} poly_term_t;

	typedef struct {
		logic signed [spadd_pkg::SUM_W-1:0] coef;
		logic [spadd_pkg::EXP_W-1:0]        expo;
		logic                               term_valid;
		logic                               last_term;
		logic                               overflow;
	} merged_term_t;

	// Polynomial sum predictor plus the queue of merged terms still owed by the block
	class poly_sum_board;
		poly_term_t   first_store[STORE_DEPTH];
		poly_term_t   second_store[STORE_DEPTH];
		int unsigned  first_len;
		int unsigned  second_len;
		bit           dropped;
		merged_term_t awaited_terms[$];
		int unsigned  mismatches;

		function new();
			first_len = 0;
			second_len = 0;
			dropped = 0;
			mismatches = 0;
		endfunction

		function int unsigned pending();
			return awaited_terms.size();
		endfunction

		task report(string what);
			$display("[%0t] MISMATCH: %s", $realtime, what);
			mismatches++;
		endtask

		// Update the stores for one accepted transaction; a run queues the merged terms
		function void note_transaction(logic [1:0] op,
				logic signed [spadd_pkg::COEF_W-1:0] c, logic [spadd_pkg::EXP_W-1:0] e);
			merged_term_t held;
			bit           have_held;
			int unsigned  i;
			int unsigned  j;
			int unsigned  k;
			held = '{coef: '0, expo: '0, term_valid: 1'b0, last_term: 1'b1,
				overflow: dropped};
			have_held = 0;
			i = 0;
			j = 0;
			k = 0;
			case (op)
				spadd_pkg::OP_APPEND_FIRST: begin
					if (first_len >= STORE_DEPTH) dropped = 1;
					else begin
						first_store[first_len] = '{coef: c, expo: e};
						first_len++;
					end
				end
				spadd_pkg::OP_APPEND_SECOND: begin
					if (second_len >= STORE_DEPTH) dropped = 1;
					else begin
						second_store[second_len] = '{coef: c, expo: e};
						second_len++;
					end
				end
				spadd_pkg::OP_RUN: begin
					// Merge the heads; push each term once its successor is known
					while ((i < first_len || j < second_len)
							&& k < spadd_pkg::MAX_RESULTS) begin
						if (have_held) awaited_terms.push_back(held);
						held.term_valid = 1'b1;
						held.last_term = 1'b0;
						held.overflow = dropped;
						if (i < first_len && j < second_len &&
								first_store[i].expo == second_store[j].expo) begin
							held.coef = first_store[i].coef + second_store[j].coef;
							held.expo = first_store[i].expo;
							i++;
							j++;
						end else if (i < first_len && (j >= second_len ||
								first_store[i].expo > second_store[j].expo)) begin
							held.coef = first_store[i].coef;
							held.expo = first_store[i].expo;
							i++;
						end else begin
							held.coef = second_store[j].coef;
							held.expo = second_store[j].expo;
							j++;
						end
						have_held = 1;
						k++;
					end
					// Both lists empty leaves the empty result built above
					held.last_term = 1'b1;
					awaited_terms.push_back(held);
					first_len = 0;
					second_len = 0;
					dropped = 0;
				end
				default: ;
			endcase
		endfunction

		// Compare one accepted result with the oldest owed term
		task check_term(logic signed [spadd_pkg::SUM_W-1:0] coef,
				logic [spadd_pkg::EXP_W-1:0] expo, logic tv, logic lt, logic ov);
			merged_term_t want;
			if (awaited_terms.size() == 0) begin
				report($sformatf("unexpected result coef %0d exp %0d", coef, expo));
				return;
			end
			want = awaited_terms.pop_front();
			if (coef !== want.coef)
				report($sformatf("sum_coefficient got %0d want %0d", coef, want.coef));
			if (expo !== want.expo)
				report($sformatf("sum_exponent got %0d want %0d", expo, want.expo));
			if (tv !== want.term_valid)
				report($sformatf("term_valid got %b want %b", tv, want.term_valid));
			if (lt !== want.last_term)
				report($sformatf("last_term got %b want %b", lt, want.last_term));
			if (ov !== want.overflow)
				report($sformatf("overflow got %b want %b", ov, want.overflow));
		endtask
	endclass

	logic clk;
	logic arst_n;

	spadd_in_if  term_if();
	spadd_out_if res_if();

	sparse_polynomial_add_merge_core #(
		.MAX_TERMS(STORE_DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.term_in   (term_if),
		.result_out(res_if)
	);

	poly_sum_board sb;
	int unsigned   items_sent;
	int unsigned   results_seen;
	int unsigned   send_calm;
	int unsigned   cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Mostly no gap, sometimes short, rarely long; calm stretches have none
	function automatic int unsigned pick_gap(ref int unsigned calm);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (roll < 4) calm = $urandom_range(30, 120);
		if (roll < 60) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drop valid to leave an idle gap on the input
	task automatic idle_input(int unsigned n);
		if (n > 0) begin
			@(negedge clk);
			term_if.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Offer one transaction and hold it until accepted
	task automatic send(logic [1:0] op, logic signed [spadd_pkg::COEF_W-1:0] c,
			logic [spadd_pkg::EXP_W-1:0] e);
		@(negedge clk);
		term_if.valid <= 1'b1;
		term_if.opcode <= op;
		term_if.coefficient <= c;
		term_if.exponent <= e;
		do @(posedge clk); while (!term_if.ready);
		sb.note_transaction(op, c, e);
		if (op != OP_IGNORED) items_sent++;
		idle_input(pick_gap(send_calm));
	endtask

	// Stop sending until the block has delivered every owed term
	task automatic drain_pause();
		@(negedge clk);
		term_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Load two lists and run them; noisy sequences are unsorted and carry ignored opcodes
	task automatic run_sequence(bit fill_up);
		int unsigned len_a;
		int unsigned len_b;
		int unsigned got_a;
		int unsigned got_b;
		int unsigned pick;
		int          expo;
		bit          noisy;
		got_a = 0;
		got_b = 0;
		noisy = ($urandom_range(0, 7) == 0);
		if (fill_up || $urandom_range(0, 9) == 0) begin
			len_a = $urandom_range(14, 20);
			len_b = $urandom_range(10, 20);
		end else begin
			len_a = $urandom_range(0, 6);
			len_b = $urandom_range(0, 6);
		end
		expo = $urandom_range(200, 1023);
		while (got_a < len_a || got_b < len_b) begin
			if (noisy) expo = $urandom_range(0, 1023);
			pick = $urandom_range(0, 2);
			if (got_a >= len_a) pick = 1;
			else if (got_b >= len_b) pick = 0;
			if (pick != 1) begin
				send(spadd_pkg::OP_APPEND_FIRST, spadd_pkg::COEF_W'($urandom),
					spadd_pkg::EXP_W'(expo));
				got_a++;
			end
			if (pick != 0 && got_b < len_b) begin
				send(spadd_pkg::OP_APPEND_SECOND, spadd_pkg::COEF_W'($urandom),
					spadd_pkg::EXP_W'(expo));
				got_b++;
			end
			if (noisy && $urandom_range(0, 3) == 0)
				send(OP_IGNORED, spadd_pkg::COEF_W'($urandom),
					spadd_pkg::EXP_W'($urandom));
			if (!noisy) begin
				expo = expo - int'($urandom_range(1, 40));
				if (expo < 0) expo = 0;
			end
		end
		send(spadd_pkg::OP_RUN, spadd_pkg::COEF_W'($urandom), spadd_pkg::EXP_W'($urandom));
	endtask

	// Result side: random stalls, one long hold to back the block up
	initial begin
		int unsigned stall_left;
		int unsigned calm;
		int unsigned roll;
		bit          held_long;
		stall_left = 0;
		calm = 0;
		held_long = 0;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (results_seen >= 30 && !held_long) begin
				stall_left = LONG_HOLD;
				held_long = 1;
			end
			if (stall_left == 0 && calm > 0) calm--;
			else if (stall_left == 0) begin
				roll = $urandom_range(0, 99);
				if (roll < 3) calm = $urandom_range(40, 150);
				else if (roll < 22) stall_left = $urandom_range(1, 3);
				else if (roll < 25) stall_left = $urandom_range(10, 40);
			end
			res_if.ready <= (stall_left == 0);
			if (stall_left > 0) stall_left--;
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				sb.check_term(res_if.sum_coefficient, res_if.sum_exponent,
					res_if.term_valid, res_if.last_term, res_if.overflow);
				results_seen++;
			end
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("sparse_polynomial_add_merge_core regression: fail");
		$finish;
	end

	initial begin
		int unsigned seq_idx;
		sb = new();
		items_sent = 0;
		results_seen = 0;
		send_calm = 0;
		seq_idx = 0;
		term_if.valid = 1'b0;
		term_if.opcode = spadd_pkg::OP_APPEND_FIRST;
		term_if.coefficient = '0;
		term_if.exponent = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty run, ignored opcode, field extremes, zero sum, leftovers, unsorted
		send(spadd_pkg::OP_RUN, 16'sd0, 10'd0);
		send(OP_IGNORED, -16'sd1, 10'd1023);
		send(spadd_pkg::OP_APPEND_FIRST, 16'sd32767, 10'd1023);
		send(spadd_pkg::OP_APPEND_SECOND, 16'sd32767, 10'd1023);
		send(spadd_pkg::OP_APPEND_FIRST, -16'sd32768, 10'd0);
		send(spadd_pkg::OP_APPEND_SECOND, -16'sd32768, 10'd0);
		send(spadd_pkg::OP_RUN, 16'sd0, 10'd0);
		send(spadd_pkg::OP_APPEND_FIRST, 16'sd5, 10'd10);
		send(spadd_pkg::OP_APPEND_SECOND, -16'sd5, 10'd10);
		send(spadd_pkg::OP_APPEND_SECOND, 16'sd3, 10'd4);
		send(spadd_pkg::OP_APPEND_SECOND, -16'sd9, 10'd1);
		send(spadd_pkg::OP_RUN, -16'sd1, 10'd1023);
		send(spadd_pkg::OP_APPEND_FIRST, 16'sd1, 10'd2);
		send(spadd_pkg::OP_APPEND_FIRST, 16'sd2, 10'd900);
		send(spadd_pkg::OP_APPEND_SECOND, 16'sd7, 10'd500);
		send(spadd_pkg::OP_RUN, 16'sd0, 10'd0);
		send(OP_IGNORED, 16'sd0, 10'd0);
		send(spadd_pkg::OP_APPEND_FIRST, -16'sd2, 10'd700);
		send(spadd_pkg::OP_RUN, 16'sd0, 10'd0);
		send(spadd_pkg::OP_RUN, 16'sd0, 10'd0);

		// Random load/run sequences; the first loads long lists that can overfill either store
		while (items_sent < ITEM_TARGET) begin
			if (seq_idx == 6 || seq_idx == 30) drain_pause();
			run_sequence(seq_idx == 0);
			seq_idx++;
		end
		@(negedge clk);
		term_if.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("sparse_polynomial_add_merge_core regression: pass");
		else
			$display("sparse_polynomial_add_merge_core regression: fail");
		$finish;
	end

endmodule
